// ===== rtl/sdsf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsf_pkg
// Constants and types for the data-set SysEx framer.
// ----------------------------------------------------------------------------
package sdsf_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] SYX_START  = 8'hF0;
    localparam logic [7:0] SYX_MFR_ID = 8'h41;
    localparam logic [7:0] SYX_DEV_ID = 8'h10;
    localparam logic [7:0] SYX_MODEL  = 8'h16;
    localparam logic [7:0] SYX_CMD_DT = 8'h12;
    localparam logic [7:0] SYX_END    = 8'hF7;

    // byte slots of one transaction's output, in emit order
    typedef enum logic [3:0] {
        POS_START, POS_MFR, POS_DEV, POS_MODEL, POS_CMD,
        POS_ADDR2, POS_ADDR1, POS_ADDR0,
        POS_DATA, POS_CSUM, POS_END
    } pos_t;

    typedef struct packed {
        logic       hdr;
        logic       data_en;
        logic       tail;
        logic       ovf;
        logic [6:0] a2;
        logic [6:0] a1;
        logic [6:0] a0;
        logic [7:0] data;
        logic [6:0] csum;
    } job_t;

endpackage

// ===== rtl/sysex_data_set_framer_top.sv =====
// The first output byte passes through the pending-job register, then the output register.
// One output byte per cycle while m_ready does not stall; an input transaction yields
//   1..11 result bytes, and a new one is taken as the pending job's last byte goes out.
// Items without results produce no bytes. Reset (aresetn low, synchronous) clears
//   the checksum, count, overflow flag, pending job and output valid.
// ----------------------------------------------------------------------------
// sysex_data_set_framer_top
// Frames a data-set SysEx message: header and address on the first item,
// payload bytes with a running 7-bit checksum, checksum and end byte last.
// ----------------------------------------------------------------------------
module sysex_data_set_framer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_address,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_has_data,
    input  logic        s_first_item,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_end_of_run,
    output logic        m_overflow
);
    import sdsf_pkg::*;

    // message state
    logic [6:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    // pending job: the result bytes of one accepted transaction
    job_t job_reg, job_next;
    logic job_valid_reg, job_valid_next;
    pos_t pos_reg, pos_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_eor_reg, m_eor_next;
    logic       m_ovf_reg, m_ovf_next;

    logic       s_fire, out_load, job_done;
    logic       pos_last;
    pos_t       pos_adv, pos_start;
    logic [7:0] pos_byte;

    // item front end
    logic [6:0]       a2, a1, a0, seed, sum_base, sum_upd;
    logic [CNT_W-1:0] cnt_base;
    logic             ovf_base, take, any_out;

    assign a2   = s_address[22:16];
    assign a1   = s_address[14:8];
    assign a0   = s_address[6:0];
    assign seed = 7'd0 - a2 - a1 - a0;

    assign sum_base = s_first_item ? seed : sum_reg;
    assign cnt_base = s_first_item ? '0 : cnt_reg;
    assign ovf_base = s_first_item ? 1'b0 : ovf_reg;
    assign take     = s_has_data && (cnt_base < CNT_W'(MAX_PAYLOAD));
    assign sum_upd  = take ? (sum_base - s_payload_byte[6:0]) : sum_base;
    assign any_out  = s_first_item || take || s_last_item;

    // emitter: walk the enabled slots of the pending job
    always_comb begin
        pos_adv  = POS_END;
        pos_last = 1'b1;
        pos_byte = SYX_END;
        case (pos_reg)
            POS_START: begin pos_byte = SYX_START;  pos_adv = POS_MFR;   pos_last = 1'b0; end
            POS_MFR:   begin pos_byte = SYX_MFR_ID; pos_adv = POS_DEV;   pos_last = 1'b0; end
            POS_DEV:   begin pos_byte = SYX_DEV_ID; pos_adv = POS_MODEL; pos_last = 1'b0; end
            POS_MODEL: begin pos_byte = SYX_MODEL;  pos_adv = POS_CMD;   pos_last = 1'b0; end
            POS_CMD:   begin pos_byte = SYX_CMD_DT; pos_adv = POS_ADDR2; pos_last = 1'b0; end
            POS_ADDR2: begin pos_byte = {1'b0, job_reg.a2}; pos_adv = POS_ADDR1; pos_last = 1'b0; end
            POS_ADDR1: begin pos_byte = {1'b0, job_reg.a1}; pos_adv = POS_ADDR0; pos_last = 1'b0; end
            POS_ADDR0: begin
                pos_byte = {1'b0, job_reg.a0};
                pos_adv  = job_reg.data_en ? POS_DATA : POS_CSUM;
                pos_last = !job_reg.data_en && !job_reg.tail;
            end
            POS_DATA: begin
                pos_byte = job_reg.data;
                pos_adv  = POS_CSUM;
                pos_last = !job_reg.tail;
            end
            POS_CSUM:  begin pos_byte = {1'b0, job_reg.csum}; pos_adv = POS_END; pos_last = 1'b0; end
            POS_END:   begin pos_byte = SYX_END; pos_adv = POS_END; pos_last = 1'b1; end
            default:   begin pos_byte = SYX_END; pos_adv = POS_END; pos_last = 1'b1; end
        endcase
    end

    assign out_load = !m_valid_reg || m_ready;
    assign job_done = out_load && job_valid_reg && pos_last;
    assign s_ready  = !job_valid_reg || job_done;
    assign s_fire   = s_valid && s_ready;

    assign pos_start = s_first_item ? POS_START : (take ? POS_DATA : POS_CSUM);

    always_comb begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_eor_next     = m_eor_reg;
        m_ovf_next     = m_ovf_reg;

        if (out_load) begin
            m_valid_next = job_valid_reg;
            m_byte_next  = pos_byte;
            m_eor_next   = pos_last;
            m_ovf_next   = job_reg.ovf;
            if (job_valid_reg) begin
                pos_next = pos_adv;
                if (pos_last) begin
                    job_valid_next = 1'b0;
                end
            end
        end

        if (s_fire) begin
            job_next.hdr     = s_first_item;
            job_next.data_en = take;
            job_next.tail    = s_last_item;
            job_next.ovf     = ovf_base || (s_has_data && !take);
            job_next.a2      = a2;
            job_next.a1      = a1;
            job_next.a0      = a0;
            job_next.data    = s_payload_byte;
            job_next.csum    = sum_upd;
            job_valid_next   = any_out;
            pos_next         = pos_start;
            if (s_last_item) begin
                sum_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end else begin
                sum_next = sum_upd;
                cnt_next = take ? cnt_base + CNT_W'(1) : cnt_base;
                ovf_next = ovf_base || (s_has_data && !take);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
            pos_reg       <= POS_START;
            m_valid_reg   <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            job_valid_reg <= job_valid_next;
            pos_reg       <= pos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_byte_reg <= m_byte_next;
        m_eor_reg  <= m_eor_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_end_of_run = m_eor_reg;
    assign m_overflow   = m_ovf_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count above limit");

    a_tail_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last_item |=> sum_reg == 7'd0 && cnt_reg == '0 && !ovf_reg)
        else $error("state not cleared after tail");

    a_ready_job: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && job_valid_reg |-> job_done)
        else $error("new transaction taken over pending job");

    a_skip_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg && !job_reg.hdr |-> pos_reg == POS_DATA || pos_reg == POS_CSUM
            || pos_reg == POS_END)
        else $error("header slot emitted without first item");
`endif

endmodule
